// ----- design/ght_pkg.sv -----
// Shared types and constants for the generational handle table.
// No dependencies; every other design file refers to it by scoped name.
`default_nettype none

package ght_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int IDX_W          = 16;     // slot field of a handle
  localparam int GEN_W          = 14;
  localparam int SIZE_W         = 15;
  localparam int REQ_W          = 16;
  localparam int HANDLE_W       = 32;
  localparam int SCAN_LANES     = 16;     // live bits examined per scan cycle
  localparam int LANE_W         = 4;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 15'd4096;
  localparam logic [33:0]       BYTE_LIMIT   = 34'(64 * 1024 * 1024);
  localparam logic [1:0]        TAG_BITS     = 2'b01;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_SIZE   = 2'd1;
  localparam logic [1:0] STAT_FULL       = 2'd2;
  localparam logic [1:0] STAT_BAD_HANDLE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } row_t;

  // update of the per-slot flag bits
  typedef struct packed {
    logic             we;
    logic             live;
    logic [IDX_W-1:0] idx;
  } flag_cmd_t;

endpackage

`default_nettype wire

// ----- design/ght_slot_mem.sv -----
// Slot row store: generation, width and height per slot.
// One write port, one registered read port. Uses ght_pkg.
`default_nettype none

module ght_slot_mem #(
  parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF,
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output ght_pkg::row_t         rd_row,
  input  wire logic             wr_en,
  input  wire logic [SLOT_W-1:0] wr_addr,
  input  ght_pkg::row_t         wr_row
);

  ght_pkg::row_t slot_mem [SLOT_COUNT];
  ght_pkg::row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= slot_mem[rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

`default_nettype wire

// ----- design/ght_slot_flags.sv -----
// Per-slot live and generation-written bits, plus the free-slot scanner
// that checks one group of live bits per cycle. Uses ght_pkg.
`default_nettype none

module ght_slot_flags #(
  parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF,
  localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int LANES   = ght_pkg::SCAN_LANES,
  localparam int NCHUNK  = (SLOT_COUNT + LANES - 1) / LANES,
  localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  ght_pkg::flag_cmd_t      cmd,
  input  wire logic [SLOT_W-1:0]  live_idx,
  output logic                    live_q,
  input  wire logic [SLOT_W-1:0]  gen_idx,
  output logic                    gen_ok_q,
  input  wire logic [CHUNK_W-1:0] scan_chunk,
  output logic                    scan_hit,
  output logic [ght_pkg::LANE_W-1:0] scan_pos
);

  logic [SLOT_COUNT-1:0]   live_r;
  logic [SLOT_COUNT-1:0]   gen_ok_r;
  logic [NCHUNK*LANES-1:0] live_pad;
  logic [LANES-1:0]        group;
  logic [SLOT_W-1:0]       cmd_slot;

  assign cmd_slot = cmd.idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      gen_ok_r <= '0;
    end else if (cmd.we) begin
      live_r[cmd_slot]   <= cmd.live;
      gen_ok_r[cmd_slot] <= 1'b1;
    end
  end

  assign live_q   = live_r[live_idx];
  assign gen_ok_q = gen_ok_r[gen_idx];

  // slots past the end look occupied so the scan never returns them
  for (genvar k = 0; k < NCHUNK * LANES; k++) begin : g_pad
    if (k < SLOT_COUNT) begin : g_real
      assign live_pad[k] = live_r[k];
    end else begin : g_fill
      assign live_pad[k] = 1'b1;
    end
  end

  assign group = live_pad[scan_chunk * LANES +: LANES];

  always_comb begin
    scan_hit = 1'b0;
    scan_pos = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (!group[k]) begin
        scan_hit = 1'b1;
        scan_pos = ght_pkg::LANE_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/generational_handle_table.sv -----
// Generational handle table: sequencer, size check, handle check, result register.
// Errors in size or handle go from decode to the result; lookup and release read the row first;
// allocate scans for a free slot, then reads it; the scan checks 16 slots a cycle.
// A full table ends the scan. One word in work at a time; in_ready rises with out_valid;
// a stalled result word holds the sequencer in its result state.
// Reset (rst_n low, synchronous) clears live/generation bits, max texture size 4096.
`default_nettype none

module generational_handle_table #(
  parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_operation,
  input  wire logic [ght_pkg::HANDLE_W-1:0] in_handle_in,
  input  wire logic [ght_pkg::REQ_W-1:0]    in_req_width,
  input  wire logic [ght_pkg::REQ_W-1:0]    in_req_height,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [ght_pkg::HANDLE_W-1:0]      out_handle_out,
  output logic [ght_pkg::SIZE_W-1:0]        out_slot_width,
  output logic [ght_pkg::SIZE_W-1:0]        out_slot_height,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ght_pkg::SIZE_W-1:0]   cfg_wr_data
);

  localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LANES   = ght_pkg::SCAN_LANES;
  localparam int NCHUNK  = (SLOT_COUNT + LANES - 1) / LANES;
  localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int FULL_W  = CHUNK_W + ght_pkg::LANE_W;
  localparam int IDX_W   = ght_pkg::IDX_W;
  localparam int GEN_W   = ght_pkg::GEN_W;
  localparam int SIZE_W  = ght_pkg::SIZE_W;

  ght_pkg::state_t state_r, state_nxt;

  logic [1:0]                 op_r;
  logic [ght_pkg::HANDLE_W-1:0] handle_r;
  logic [ght_pkg::REQ_W-1:0]  w_r, h_r;
  logic [SLOT_W-1:0]          idx_r, idx_nxt;
  logic [CHUNK_W-1:0]         chunk_r, chunk_nxt;
  logic [SIZE_W-1:0]          max_size_r;

  logic [1:0]                 res_status_r, res_status_nxt;
  logic [ght_pkg::HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [SIZE_W-1:0]          res_w_r, res_w_nxt, res_h_r, res_h_nxt;

  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [ght_pkg::HANDLE_W-1:0] out_handle_r;
  logic [SIZE_W-1:0]          out_w_r, out_h_r;
  logic                       load_out;

  // size check
  logic [31:0] area;
  logic        bad_size;
  assign area     = {16'd0, w_r} * {16'd0, h_r};
  assign bad_size = (w_r == '0) || (h_r == '0)
                 || (w_r > {1'b0, max_size_r}) || (h_r > {1'b0, max_size_r})
                 || ({area, 2'b00} > ght_pkg::BYTE_LIMIT);

  // handle check (generation compared after the row read)
  logic [IDX_W-1:0]  hdl_enc, hdl_idx16;
  logic [SLOT_W-1:0] hdl_idx;
  logic [GEN_W-1:0]  hdl_gen;
  logic              hdl_ok;
  assign hdl_enc   = handle_r[IDX_W-1:0];
  assign hdl_idx16 = hdl_enc - IDX_W'(1);
  assign hdl_idx   = hdl_idx16[SLOT_W-1:0];
  assign hdl_gen   = handle_r[IDX_W +: GEN_W];
  assign hdl_ok    = (handle_r[ght_pkg::HANDLE_W-1 -: 2] == ght_pkg::TAG_BITS)
                  && (hdl_enc != '0)
                  && ({1'b0, hdl_idx16} < (IDX_W+1)'(SLOT_COUNT));

  // flags and memory
  ght_pkg::flag_cmd_t fcmd;
  ght_pkg::row_t      rd_row, wr_row;
  logic               rd_en, wr_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic               live_q, gen_ok_q, scan_hit;
  logic [ght_pkg::LANE_W-1:0] scan_pos;
  logic [FULL_W-1:0]  scan_full;
  logic [SLOT_W-1:0]  scan_slot;

  assign scan_full = {chunk_r, scan_pos};
  assign scan_slot = scan_full[SLOT_W-1:0];

  ght_slot_flags #(.SLOT_COUNT(SLOT_COUNT)) u_flags (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (fcmd),
    .live_idx   (hdl_idx),
    .live_q     (live_q),
    .gen_idx    (idx_r),
    .gen_ok_q   (gen_ok_q),
    .scan_chunk (chunk_r),
    .scan_hit   (scan_hit),
    .scan_pos   (scan_pos)
  );

  ght_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_row  (wr_row)
  );

  // never-written rows count as generation zero
  logic [GEN_W-1:0] gen_cur, gen_inc, gen_next;
  assign gen_cur  = gen_ok_q ? rd_row.gen : '0;
  assign gen_inc  = gen_cur + GEN_W'(1);
  assign gen_next = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = hdl_idx;
    wr_en          = 1'b0;
    wr_row         = '0;
    fcmd           = '0;
    fcmd.idx       = IDX_W'(idx_r);
    idx_nxt        = idx_r;
    chunk_nxt      = chunk_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_w_nxt      = res_w_r;
    res_h_nxt      = res_h_r;
    load_out       = 1'b0;

    case (state_r)
      ght_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ght_pkg::S_DECODE;
        end
      end

      ght_pkg::S_DECODE: begin
        chunk_nxt      = '0;
        res_status_nxt = ght_pkg::STAT_BAD_HANDLE;
        res_handle_nxt = '0;
        res_w_nxt      = '0;
        res_h_nxt      = '0;
        state_nxt      = ght_pkg::S_RESP;
        case (op_r)
          ght_pkg::OP_ALLOC: begin
            if (bad_size) begin
              res_status_nxt = ght_pkg::STAT_BAD_SIZE;
            end else begin
              state_nxt = ght_pkg::S_SCAN;
            end
          end
          ght_pkg::OP_LOOKUP, ght_pkg::OP_RELEASE: begin
            if (hdl_ok && live_q) begin
              rd_en     = 1'b1;
              rd_addr   = hdl_idx;
              idx_nxt   = hdl_idx;
              state_nxt = ght_pkg::S_READ;
            end
          end
          default: begin
          end
        endcase
      end

      ght_pkg::S_SCAN: begin
        if (scan_hit) begin
          rd_en     = 1'b1;
          rd_addr   = scan_slot;
          idx_nxt   = scan_slot;
          state_nxt = ght_pkg::S_READ;
        end else if (chunk_r == CHUNK_W'(NCHUNK - 1)) begin
          res_status_nxt = ght_pkg::STAT_FULL;
          state_nxt      = ght_pkg::S_RESP;
        end else begin
          chunk_nxt = chunk_r + CHUNK_W'(1);
        end
      end

      ght_pkg::S_READ: begin
        state_nxt = ght_pkg::S_RESP;
        if (op_r == ght_pkg::OP_ALLOC) begin
          wr_en          = 1'b1;
          wr_row.gen     = gen_cur;
          wr_row.width   = w_r[SIZE_W-1:0];
          wr_row.height  = h_r[SIZE_W-1:0];
          fcmd.we        = 1'b1;
          fcmd.live      = 1'b1;
          res_status_nxt = ght_pkg::STAT_OK;
          res_handle_nxt = {ght_pkg::TAG_BITS, gen_cur, IDX_W'(idx_r) + IDX_W'(1)};
          res_w_nxt      = w_r[SIZE_W-1:0];
          res_h_nxt      = h_r[SIZE_W-1:0];
        end else if (gen_cur == hdl_gen) begin
          res_status_nxt = ght_pkg::STAT_OK;
          res_handle_nxt = handle_r;
          res_w_nxt      = rd_row.width;
          res_h_nxt      = rd_row.height;
          if (op_r == ght_pkg::OP_RELEASE) begin
            wr_en      = 1'b1;
            wr_row.gen = gen_next;
            fcmd.we    = 1'b1;
            fcmd.live  = 1'b0;
          end
        end
        // on a generation mismatch the bad-handle result from decode stands
      end

      ght_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ght_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ght_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ght_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      max_size_r  <= ght_pkg::MAX_SIZE_RST;
      chunk_r     <= '0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        max_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_operation;
      handle_r <= in_handle_in;
      w_r      <= in_req_width;
      h_r      <= in_req_height;
    end
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_w_r      <= res_w_nxt;
    res_h_r      <= res_h_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_handle_r <= res_handle_r;
      out_w_r      <= res_w_r;
      out_h_r      <= res_h_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle_out  = out_handle_r;
  assign out_slot_width  = out_w_r;
  assign out_slot_height = out_h_r;

endmodule

`default_nettype wire

// ----- design/ght_checker.sv -----
// Port-level checks for the generational handle table, bound to the top level.
// Uses ght_pkg status codes.
`default_nettype none

module ght_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_handle_out,
  input wire logic [14:0] out_slot_width,
  input wire logic [14:0] out_slot_height
);

  // one word in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high the cycle after an accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_handle_out)
                                   && $stable(out_status)))
    else $error("stalled result word changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ght_pkg::STAT_OK) |->
      (out_handle_out == '0 && out_slot_width == '0 && out_slot_height == '0))
    else $error("failed result carries nonzero fields");

  a_ok_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ght_pkg::STAT_OK) |->
      (out_handle_out[31:30] == ght_pkg::TAG_BITS && out_handle_out[15:0] != '0
       && out_slot_width != '0 && out_slot_height != '0))
    else $error("ok result with malformed handle or empty size");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_handle_out  (out_handle_out),
  .out_slot_width  (out_slot_width),
  .out_slot_height (out_slot_height)
);

`default_nettype wire
